### hw/rtl/spt_pkg.sv
// Shared types, codes and constants of the stream prefetch tracker.
package spt_pkg;

	localparam int MONITOR_COUNT_DEF = 64;
	localparam int LINE_SHIFT_DEF    = 6;

	localparam int ADDR_W    = 64;
	localparam int DEG_W     = 4;
	localparam int DIST_W    = 8;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [DEG_W-1:0]  DEG_RESET  = 4'd3;
	localparam logic [DEG_W-1:0]  MAX_DEGREE = 4'd8;
	localparam logic [DIST_W-1:0] DIST_RESET = 8'd10;

	localparam logic [CFG_IDX_W-1:0] REG_DEGREE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DISTANCE = 1'b1;

	localparam logic [1:0] STAGE_NEW = 2'd0;
	localparam logic [1:0] STAGE_DIR = 2'd1;
	localparam logic [1:0] STAGE_RUN = 2'd2;

	typedef struct packed {
		logic [1:0]        stage;
		logic [ADDR_W-1:0] start_line;
		logic [ADDR_W-1:0] end_line;
		logic              descending;
		logic [ADDR_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic line_lt_s;
		logic line_gt_s;
		logic line_lt_e;
		logic line_gt_e;
		logic s_lt_e;
		logic s_gt_e;
		logic near_up;
		logic near_down;
		logic ahead;
	} flags_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT,
		ST_UPD,
		ST_ALLOC
	} state_t;

endpackage

### hw/rtl/spt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/spt_cmp.sv
// Shared compare unit: one monitor entry per cycle, flags registered, then the match rule.
module spt_cmp #(
	parameter int MONITOR_COUNT = spt_pkg::MONITOR_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             scan_on,
	input  logic                             rd_valid,
	input  logic [$clog2(MONITOR_COUNT)-1:0] rd_idx,
	input  spt_pkg::entry_t                  rd_entry,
	input  logic [spt_pkg::ADDR_W-1:0]       line,
	input  logic [spt_pkg::DIST_W-1:0]       distance,
	output logic                             ent_valid,
	output logic [$clog2(MONITOR_COUNT)-1:0] ent_idx,
	output spt_pkg::entry_t                  ent,
	output spt_pkg::flags_t                  ent_flags,
	output logic                             hit
);

	localparam int IDX_W = $clog2(MONITOR_COUNT);

	logic [spt_pkg::ADDR_W-1:0] dist_ext;
	logic [spt_pkg::ADDR_W-1:0] diff;
	spt_pkg::flags_t            flags;
	logic                       v_s2;
	logic [IDX_W-1:0]           idx_s2;
	spt_pkg::entry_t            ent_s2;
	spt_pkg::flags_t            flags_s2;
	logic                       rule;

	assign dist_ext = {{(spt_pkg::ADDR_W - spt_pkg::DIST_W){1'b0}}, distance};
	assign diff     = line - rd_entry.start_line;

	always_comb begin
		flags.line_lt_s = line < rd_entry.start_line;
		flags.line_gt_s = line > rd_entry.start_line;
		flags.line_lt_e = line < rd_entry.end_line;
		flags.line_gt_e = line > rd_entry.end_line;
		flags.s_lt_e    = rd_entry.start_line < rd_entry.end_line;
		flags.s_gt_e    = rd_entry.start_line > rd_entry.end_line;
		flags.near_up   = line < (rd_entry.start_line + dist_ext);
		flags.near_down = line > (rd_entry.start_line - dist_ext);
		flags.ahead     = (diff[spt_pkg::ADDR_W-1:spt_pkg::DIST_W] == '0) &&
			(diff[spt_pkg::DIST_W-1:0] < distance);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= rd_valid && scan_on && !hit;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2   <= rd_idx;
		ent_s2   <= rd_entry;
		flags_s2 <= flags;
	end

	always_comb begin
		case (ent_s2.stage)
			spt_pkg::STAGE_RUN: begin
				rule = (!flags_s2.line_lt_s && !flags_s2.line_gt_e) ||
					(!flags_s2.line_gt_s && !flags_s2.line_lt_e);
			end
			spt_pkg::STAGE_DIR: begin
				rule = ((flags_s2.s_lt_e && flags_s2.line_gt_e) ||
					(flags_s2.s_gt_e && flags_s2.line_lt_e)) &&
					(ent_s2.descending ? flags_s2.near_down : flags_s2.ahead);
			end
			spt_pkg::STAGE_NEW: begin
				rule = (flags_s2.line_lt_s || flags_s2.line_gt_s) &&
					flags_s2.near_up && flags_s2.near_down;
			end
			default: begin
				rule = 1'b0;
			end
		endcase
	end

	assign hit       = v_s2 && scan_on && rule;
	assign ent_valid = v_s2;
	assign ent_idx   = idx_s2;
	assign ent       = ent_s2;
	assign ent_flags = flags_s2;

endmodule

### hw/rtl/stream_prefetch_tracker.sv
// Stream prefetch tracker: a hit access is taken in the idle state and the block is ready again
// at once. A miss stalls the input while the used monitors are read one per cycle through the
// single read port of the monitor table; a match is known once its entry has passed the
// registered read and the registered compare flags. A miss that matches nothing scans every
// used monitor and then allocates one (the oldest stamp is replaced in a full table; an empty
// table skips the scan). A match in the windowed stage then sends degree prefetch beats (at
// most 8), one per cycle while the output does not stall, and every match ends with a write of
// the monitor back. The table needs no clearing after reset.
module stream_prefetch_tracker #(
	parameter int MONITOR_COUNT = spt_pkg::MONITOR_COUNT_DEF,
	parameter int LINE_SHIFT    = spt_pkg::LINE_SHIFT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [spt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [spt_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [spt_pkg::ADDR_W-1:0]    access_address,
	input  logic                          is_hit,
	input  logic [spt_pkg::ADDR_W-1:0]    cycle_now,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [spt_pkg::ADDR_W-1:0]    prefetch_address,
	output logic                          last_of_run
);

	localparam int IDX_W   = $clog2(MONITOR_COUNT);
	localparam int CNT_W   = $clog2(MONITOR_COUNT + 1);
	localparam int ENTRY_W = $bits(spt_pkg::entry_t);
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MONITOR_COUNT);

	spt_pkg::state_t state_q, state_d;

	logic [spt_pkg::DEG_W-1:0]  deg_q;
	logic [spt_pkg::DIST_W-1:0] dist_q;
	logic [spt_pkg::DEG_W-1:0]  deg_eff;

	logic [spt_pkg::ADDR_W-1:0] line_q;
	logic [spt_pkg::ADDR_W-1:0] now_q;
	logic [CNT_W-1:0]           used_q;
	logic [CNT_W-1:0]           rd_idx_q;
	logic                       v_s1_q;
	logic [IDX_W-1:0]           idx_s1_q;
	logic                       issue;
	logic                       full;
	logic                       in_take;

	logic [spt_pkg::ADDR_W-1:0] min_stamp_q;
	logic [IDX_W-1:0]           victim_q;

	spt_pkg::entry_t            hit_ent_q;
	logic [IDX_W-1:0]           hit_idx_q;
	logic                       hit_lt_q;

	logic [spt_pkg::ADDR_W-1:0] pf_q;
	logic [spt_pkg::ADDR_W-1:0] pf_next;
	logic [spt_pkg::DEG_W-1:0]  cnt_q;
	logic                       load;
	logic                       load_last;
	logic                       out_valid_q;
	logic [spt_pkg::ADDR_W-1:0] out_addr_q;
	logic                       out_last_q;

	logic [spt_pkg::ADDR_W-1:0] slide;
	logic                       ram_we;
	logic [IDX_W-1:0]           ram_waddr;
	spt_pkg::entry_t            ram_wentry;
	logic [ENTRY_W-1:0]         ram_rdata;
	spt_pkg::entry_t            rd_entry;

	logic                       ent_valid;
	logic [IDX_W-1:0]           ent_idx;
	spt_pkg::entry_t            ent;
	spt_pkg::flags_t            ent_flags;
	logic                       hit;
	logic                       scan_on;

	assign deg_eff = (deg_q > spt_pkg::MAX_DEGREE) ? spt_pkg::MAX_DEGREE : deg_q;
	assign full    = used_q == FULL_COUNT;
	assign scan_on = state_q == spt_pkg::ST_SCAN;
	assign issue   = scan_on && (rd_idx_q != used_q) && !hit;
	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q  <= spt_pkg::DEG_RESET;
			dist_q <= spt_pkg::DIST_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				spt_pkg::REG_DEGREE: begin
					deg_q <= cfg_data[spt_pkg::DEG_W-1:0];
				end
				spt_pkg::REG_DISTANCE: begin
					dist_q <= cfg_data[spt_pkg::DIST_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	spt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MONITOR_COUNT)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wentry),
		.re   (issue),
		.raddr(rd_idx_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	assign rd_entry = spt_pkg::entry_t'(ram_rdata);

	spt_cmp #(
		.MONITOR_COUNT(MONITOR_COUNT)
	) u_cmp (
		.clk      (clk),
		.arst_n   (arst_n),
		.scan_on  (scan_on),
		.rd_valid (v_s1_q),
		.rd_idx   (idx_s1_q),
		.rd_entry (rd_entry),
		.line     (line_q),
		.distance (dist_q),
		.ent_valid(ent_valid),
		.ent_idx  (ent_idx),
		.ent      (ent),
		.ent_flags(ent_flags),
		.hit      (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= spt_pkg::ST_IDLE;
			used_q   <= '0;
			rd_idx_q <= '0;
			v_s1_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			v_s1_q  <= issue;
			if (in_take) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (state_q == spt_pkg::ST_ALLOC && !full) begin
				used_q <= used_q + CNT_W'(1);
			end
			if (hit) begin
				cnt_q <= '0;
			end else if (load) begin
				cnt_q <= cnt_q + spt_pkg::DEG_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1_q <= rd_idx_q[IDX_W-1:0];
		if (in_take) begin
			line_q <= access_address >> LINE_SHIFT;
			now_q  <= cycle_now;
		end
		if (scan_on && ent_valid && (ent_idx == '0 || ent.stamp < min_stamp_q)) begin
			min_stamp_q <= ent.stamp;
			victim_q    <= ent_idx;
		end
		if (hit) begin
			hit_ent_q <= ent;
			hit_idx_q <= ent_idx;
			hit_lt_q  <= ent_flags.line_lt_s;
			pf_q      <= ent.end_line;
		end else if (load) begin
			pf_q <= pf_next;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			spt_pkg::ST_IDLE: begin
				if (in_valid && !is_hit) begin
					state_d = (used_q == '0) ? spt_pkg::ST_ALLOC : spt_pkg::ST_SCAN;
				end
			end
			spt_pkg::ST_SCAN: begin
				if (hit) begin
					if (ent.stage == spt_pkg::STAGE_RUN && deg_eff != '0) begin
						state_d = spt_pkg::ST_EMIT;
					end else begin
						state_d = spt_pkg::ST_UPD;
					end
				end else if (rd_idx_q == used_q && !v_s1_q && !ent_valid) begin
					state_d = spt_pkg::ST_ALLOC;
				end
			end
			spt_pkg::ST_EMIT: begin
				if (load && load_last) begin
					state_d = spt_pkg::ST_UPD;
				end
			end
			spt_pkg::ST_UPD: begin
				state_d = spt_pkg::ST_IDLE;
			end
			spt_pkg::ST_ALLOC: begin
				state_d = spt_pkg::ST_IDLE;
			end
			default: begin
				state_d = spt_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_stall = state_q != spt_pkg::ST_IDLE;

	// prefetch beats: one line step per beat from the window end
	assign load      = (state_q == spt_pkg::ST_EMIT) && (!out_valid_q || !out_stall);
	assign load_last = (cnt_q + spt_pkg::DEG_W'(1)) == deg_eff;
	assign pf_next   = hit_ent_q.descending ? pf_q - spt_pkg::ADDR_W'(1)
		: pf_q + spt_pkg::ADDR_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_addr_q <= pf_next << LINE_SHIFT;
			out_last_q <= load_last;
		end
	end

	assign out_valid        = out_valid_q;
	assign prefetch_address = out_addr_q;
	assign last_of_run      = out_last_q;

	// write back the matched monitor or allocate a new one
	assign slide = hit_ent_q.descending
		? hit_ent_q.start_line - {{(spt_pkg::ADDR_W - spt_pkg::DEG_W){1'b0}}, deg_eff}
		: hit_ent_q.start_line + {{(spt_pkg::ADDR_W - spt_pkg::DEG_W){1'b0}}, deg_eff};

	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = hit_idx_q;
		ram_wentry = hit_ent_q;
		ram_wentry.stamp = now_q;
		case (state_q)
			spt_pkg::ST_UPD: begin
				ram_we = 1'b1;
				case (hit_ent_q.stage)
					spt_pkg::STAGE_NEW: begin
						ram_wentry.stage      = spt_pkg::STAGE_DIR;
						ram_wentry.end_line   = line_q;
						ram_wentry.descending = hit_lt_q;
					end
					spt_pkg::STAGE_DIR: begin
						ram_wentry.stage    = spt_pkg::STAGE_RUN;
						ram_wentry.end_line = slide;
					end
					default: begin
						ram_wentry.start_line = slide;
						ram_wentry.end_line   = pf_q;
					end
				endcase
			end
			spt_pkg::ST_ALLOC: begin
				ram_we                = 1'b1;
				ram_waddr             = full ? victim_q : used_q[IDX_W-1:0];
				ram_wentry.stage      = spt_pkg::STAGE_NEW;
				ram_wentry.start_line = line_q;
				ram_wentry.end_line   = line_q;
				ram_wentry.descending = 1'b0;
			end
			default: begin
			end
		endcase
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= FULL_COUNT)
		else $error("monitor count beyond table depth");

	a_hit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> ent_valid && scan_on)
		else $error("match outside table scan");

	a_emit_to_upd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spt_pkg::ST_EMIT && load && load_last) |=>
		(state_q == spt_pkg::ST_UPD && out_valid && last_of_run))
		else $error("final beat not followed by write-back");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == spt_pkg::ST_UPD || state_q == spt_pkg::ST_ALLOC) && !issue)
		else $error("table written during scan");

endmodule
